// ----- hw/rtl/ecp_tre_pkg.sv -----
package ecp_tre_pkg;

    typedef enum logic [1:0] {
        CMD_ENQUEUE   = 2'd0,
        CMD_TICK      = 2'd1,
        CMD_ACK       = 2'd2,
        CMD_PORT_DOWN = 2'd3
    } cmd_t;

    // Register indexes on the configuration port (byte address = 4 * index)
    typedef enum logic [1:0] {
        REG_ACK_TIMER_RELOAD = 2'd0,
        REG_TICK_STEP        = 2'd1,
        REG_MAX_TRIES        = 2'd2
    } reg_idx_t;

    localparam logic [15:0] ACK_TIMER_RELOAD_RST = 16'd100;
    localparam logic [15:0] TICK_STEP_RST        = 16'd10;
    localparam logic [7:0]  MAX_TRIES_RST        = 8'd3;

    localparam logic [7:0]  RETRY_MAX = 8'hFF;
    localparam logic [15:0] ERROR_MAX = 16'hFFFF;

    typedef struct packed {
        cmd_t        cmd;
        logic [15:0] pdu_seq;
        logic        tlv_ok;
    } in_item_t;

    typedef struct packed {
        logic        send_now;
        logic [15:0] send_seq;
        logic        pdu_done;
        logic [15:0] done_seq;
        logic [2:0]  engine_state;
        logic [7:0]  retry_count;
        logic [15:0] error_count;
        logic [4:0]  queue_count;
        logic        enqueue_dropped;
    } out_item_t;

endpackage

// ----- hw/rtl/ecp_tre_ram.sv -----
module ecp_tre_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/ecp_transmit_retry_engine.sv -----
// ECP transmit retry engine. Commands arrive one per transfer on the s_ channel
// (enqueue a PDU sequence number, timer tick, ack received, port down) and each
// one yields exactly one result transfer on the m_ channel with the send/done
// events and the counters as they stand after the command. Each command is
// decoded and applied in the cycle it is accepted and its result is registered,
// so a new command is accepted every cycle unless the result register is full
// and m_ready is low. The PDU queue lives in a RAM read one entry ahead of the
// head; the head entry itself is kept in a register so that a pop can hand the
// next entry over without a stall.
// Timer reload, tick step and retry limit are set over the APB port at byte
// addresses 0x0, 0x4 and 0x8 and should only be changed while the block is idle.
module ecp_transmit_retry_engine
    import ecp_tre_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,

    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(QUEUE_DEPTH - 1);
    localparam logic [FW-1:0] FULL_CNT = FW'(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_INIT      = 3'd1,
        ST_TRANSMIT  = 3'd2,
        ST_COUNT_ERR = 3'd3,
        ST_WAIT      = 3'd4
    } state_t;

    function automatic logic [PW-1:0] next_idx(input logic [PW-1:0] i);
        return (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    // configuration
    logic [15:0] ack_reload_reg;
    logic [15:0] tick_step_reg;
    logic [7:0]  max_tries_reg;
    logic        cfg_wr;
    reg_idx_t    cfg_idx;

    // engine state
    state_t        state_reg, state_next;
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic          started_reg, started_next;
    logic [7:0]    retries_reg, retries_next;
    logic [15:0]   errors_reg, errors_next;
    logic [15:0]   countdown_reg, countdown_next;
    logic [15:0]   hd_seq_reg, hd_seq_next;

    // queue RAM and read-ahead bypass
    logic          ram_we;
    logic [PW-1:0] ram_raddr;
    logic [15:0]   ram_rdata;
    logic          byp_hit_reg;
    logic [15:0]   byp_data_reg;
    logic [15:0]   ahead_seq;

    out_item_t   res_reg, res_next;
    logic        res_valid_reg;
    logic        accept;
    logic [15:0] dec_timer;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_comb begin
        prdata = '0;
        case (cfg_idx)
            REG_ACK_TIMER_RELOAD: prdata = {16'd0, ack_reload_reg};
            REG_TICK_STEP:        prdata = {16'd0, tick_step_reg};
            REG_MAX_TRIES:        prdata = {24'd0, max_tries_reg};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ack_reload_reg <= ACK_TIMER_RELOAD_RST;
            tick_step_reg  <= TICK_STEP_RST;
            max_tries_reg  <= MAX_TRIES_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ACK_TIMER_RELOAD: ack_reload_reg <= pwdata[15:0];
                REG_TICK_STEP:        tick_step_reg  <= pwdata[15:0];
                REG_MAX_TRIES:        max_tries_reg  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // handshake: the result register frees up as it is taken
    assign s_ready = !res_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = res_valid_reg;
    assign m_data  = res_reg;

    assign ahead_seq = byp_hit_reg ? byp_data_reg : ram_rdata;
    assign dec_timer = (countdown_reg > tick_step_reg) ? countdown_reg - tick_step_reg : '0;

    assign ram_we    = accept && (s_data.cmd == CMD_ENQUEUE) && (fill_reg != FULL_CNT);
    assign ram_raddr = next_idx(head_next);

    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        fill_next      = fill_reg;
        started_next   = started_reg;
        retries_next   = retries_reg;
        errors_next    = errors_reg;
        countdown_next = countdown_reg;
        hd_seq_next    = hd_seq_reg;
        res_next       = '0;

        if (accept) begin
            case (s_data.cmd)
                CMD_ENQUEUE: begin
                    if (fill_reg != FULL_CNT) begin
                        tail_next = next_idx(tail_reg);
                        fill_next = fill_reg + 1'b1;
                        if (fill_reg == '0) begin
                            hd_seq_next = s_data.pdu_seq;
                        end
                    end else begin
                        res_next.enqueue_dropped = 1'b1;
                    end
                end
                CMD_TICK: begin
                    if (!s_data.tlv_ok) begin
                        // flush everything
                        head_next      = '0;
                        tail_next      = '0;
                        fill_next      = '0;
                        started_next   = 1'b0;
                        state_next     = ST_IDLE;
                        retries_next   = '0;
                        errors_next    = '0;
                        countdown_next = '0;
                    end else if (fill_reg != '0) begin
                        if (!started_reg) begin
                            started_next       = 1'b1;
                            errors_next        = '0;
                            state_next         = ST_TRANSMIT;
                            countdown_next     = ack_reload_reg;
                            retries_next       = 8'd1;
                            res_next.send_now  = 1'b1;
                            res_next.send_seq  = hd_seq_reg;
                        end else if (state_reg == ST_WAIT) begin
                            // pop the head and hand over the read-ahead entry
                            res_next.pdu_done = 1'b1;
                            res_next.done_seq = hd_seq_reg;
                            head_next         = next_idx(head_reg);
                            fill_next         = fill_reg - 1'b1;
                            started_next      = 1'b0;
                            hd_seq_next       = ahead_seq;
                        end else begin
                            countdown_next = dec_timer;
                            if (dec_timer == '0 && state_reg == ST_TRANSMIT) begin
                                if (retries_reg < max_tries_reg) begin
                                    state_next        = ST_TRANSMIT;
                                    countdown_next    = ack_reload_reg;
                                    retries_next      = (retries_reg != RETRY_MAX) ?
                                                        retries_reg + 1'b1 : retries_reg;
                                    res_next.send_now = 1'b1;
                                    res_next.send_seq = hd_seq_reg;
                                end else begin
                                    errors_next  = (errors_reg != ERROR_MAX) ?
                                                   errors_reg + 1'b1 : errors_reg;
                                    state_next   = ST_WAIT;
                                    retries_next = '0;
                                end
                            end
                        end
                    end
                end
                CMD_ACK: begin
                    if (state_reg == ST_TRANSMIT) begin
                        state_next   = ST_WAIT;
                        retries_next = '0;
                    end
                end
                CMD_PORT_DOWN: begin
                    state_next   = ST_INIT;
                    retries_next = '0;
                    errors_next  = '0;
                    started_next = 1'b0;
                end
                default: ;
            endcase

            res_next.engine_state = 3'(state_next);
            res_next.retry_count  = retries_next;
            res_next.error_count  = errors_next;
            res_next.queue_count  = 5'(fill_next);
        end
    end

    ecp_tre_ram #(
        .WIDTH (16),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (s_data.pdu_seq),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            started_reg   <= 1'b0;
            retries_reg   <= '0;
            errors_reg    <= '0;
            countdown_reg <= '0;
            res_valid_reg <= 1'b0;
            byp_hit_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            started_reg   <= started_next;
            retries_reg   <= retries_next;
            errors_reg    <= errors_next;
            countdown_reg <= countdown_next;
            // the RAM returns old data when written at the address being read
            byp_hit_reg   <= ram_we && (tail_reg == ram_raddr);
            if (accept) begin
                res_valid_reg <= 1'b1;
            end else if (m_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        hd_seq_reg   <= hd_seq_next;
        byp_data_reg <= s_data.pdu_seq;
        if (accept) begin
            res_reg <= res_next;
        end
    end

endmodule

// ----- sim/tb_ecp_transmit_retry_engine.sv -----
`timescale 1ns / 1ps

module tb_ecp_transmit_retry_engine;
    import ecp_tre_pkg::*;

    localparam int QDEPTH = 16;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS = 100;
    localparam int NUM_PHASES = 5;

    typedef enum logic [2:0] {
        ES_IDLE      = 3'd0,
        ES_INIT      = 3'd1,
        ES_TRANSMIT  = 3'd2,
        ES_GIVE_UP   = 3'd3,
        ES_WAIT      = 3'd4
    } engine_state_t;

    class retry_engine_scoreboard;
        logic [15:0]   timer_reload;
        logic [15:0]   timer_step;
        logic [7:0]    try_limit;
        logic [15:0]   seq_store [QDEPTH];
        int            head_idx;
        int            tail_idx;
        int            fill;
        bit            started;
        engine_state_t state;
        logic [7:0]    retries;
        logic [15:0]   errors;
        logic [15:0]   countdown;
        out_item_t     res;
        out_item_t     pending_results [$];
        int            mismatches;

        function new();
            timer_reload = ACK_TIMER_RELOAD_RST;
            timer_step   = TICK_STEP_RST;
            try_limit    = MAX_TRIES_RST;
            head_idx     = 0;
            tail_idx     = 0;
            fill         = 0;
            started      = 1'b0;
            state        = ES_IDLE;
            retries      = '0;
            errors       = '0;
            countdown    = '0;
            mismatches   = 0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [31:0] val);
            case (idx)
                REG_ACK_TIMER_RELOAD: timer_reload = val[15:0];
                REG_TICK_STEP:        timer_step   = val[15:0];
                REG_MAX_TRIES:        try_limit    = val[7:0];
                default: ;
            endcase
        endfunction

        function void transmit_head();
            state     = ES_TRANSMIT;
            countdown = timer_reload;
            if (retries != RETRY_MAX)
                retries++;
            res.send_now = 1'b1;
            res.send_seq = seq_store[head_idx];
        endfunction

        function void note_command(in_item_t it);
            res = '0;
            case (it.cmd)
                CMD_ENQUEUE: begin
                    if (fill < QDEPTH) begin
                        seq_store[tail_idx] = it.pdu_seq;
                        tail_idx = (tail_idx + 1) % QDEPTH;
                        fill++;
                    end else begin
                        res.enqueue_dropped = 1'b1;
                    end
                end
                CMD_TICK: begin
                    if (!it.tlv_ok) begin
                        // flush the whole queue and clear the machine
                        head_idx  = 0;
                        tail_idx  = 0;
                        fill      = 0;
                        started   = 1'b0;
                        state     = ES_IDLE;
                        retries   = '0;
                        errors    = '0;
                        countdown = '0;
                    end else if (fill != 0) begin
                        if (!started) begin
                            started = 1'b1;
                            retries = '0;
                            errors  = '0;
                            transmit_head();
                        end else if (state == ES_WAIT) begin
                            res.pdu_done = 1'b1;
                            res.done_seq = seq_store[head_idx];
                            head_idx = (head_idx + 1) % QDEPTH;
                            fill--;
                            started = 1'b0;
                        end else begin
                            countdown = (countdown > timer_step) ? countdown - timer_step : '0;
                            if (countdown == 0 && state == ES_TRANSMIT) begin
                                if (retries < try_limit) begin
                                    transmit_head();
                                end else begin
                                    if (errors != ERROR_MAX)
                                        errors++;
                                    state   = ES_WAIT;
                                    retries = '0;
                                end
                            end
                        end
                    end
                end
                CMD_ACK: begin
                    if (state == ES_TRANSMIT) begin
                        state   = ES_WAIT;
                        retries = '0;
                    end
                end
                default: begin
                    state   = ES_INIT;
                    retries = '0;
                    errors  = '0;
                    started = 1'b0;
                end
            endcase
            res.engine_state = state;
            res.retry_count  = retries;
            res.error_count  = errors;
            res.queue_count  = 5'(fill);
            pending_results.push_back(res);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $error("%s: expected %0d, got %0d", name, want, got);
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $error("result transfer with no expectation waiting");
                return;
            end
            want = pending_results.pop_front();
            compare_field("send_now", want.send_now, got.send_now);
            compare_field("send_seq", want.send_seq, got.send_seq);
            compare_field("pdu_done", want.pdu_done, got.pdu_done);
            compare_field("done_seq", want.done_seq, got.done_seq);
            compare_field("engine_state", want.engine_state, got.engine_state);
            compare_field("retry_count", want.retry_count, got.retry_count);
            compare_field("error_count", want.error_count, got.error_count);
            compare_field("queue_count", want.queue_count, got.queue_count);
            compare_field("enqueue_dropped", want.enqueue_dropped, got.enqueue_dropped);
        endfunction
    endclass

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    retry_engine_scoreboard sb;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int burst_left = 0;
    int reg_errors = 0;
    int idle_cycles = 0;

    ecp_transmit_retry_engine #(.QUEUE_DEPTH(QDEPTH)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_command(s_data);
            if (m_valid && m_ready)
                sb.check_result(m_data);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[ecp_transmit_retry_engine] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_command(input cmd_t c, input logic [15:0] seq, input logic tlv);
        in_item_t it;
        int gap;
        it.cmd     = c;
        it.pdu_seq = seq;
        it.tlv_ok  = tlv;
        gap = 0;
        while (gap < 60 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    // hold off new commands until every expected result has come back
    task automatic wait_results_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [31:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_reg(idx, val);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read_check(input reg_idx_t idx, input logic [31:0] want);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want) begin
            reg_errors++;
            $error("%s: expected %0d, got %0d", idx.name(), want, prdata);
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_timing(input logic [15:0] reload, input logic [15:0] step,
                              input logic [7:0] tries);
        apb_write(REG_ACK_TIMER_RELOAD, {16'h0, reload});
        apb_write(REG_TICK_STEP, {16'h0, step});
        apb_write(REG_MAX_TRIES, {24'h0, tries});
        apb_read_check(REG_ACK_TIMER_RELOAD, {16'h0, reload});
        apb_read_check(REG_TICK_STEP, {16'h0, step});
        apb_read_check(REG_MAX_TRIES, {24'h0, tries});
    endtask

    task automatic run_directed();
        int i;
        logic [15:0] seq;
        push_command(CMD_TICK, 16'h0000, 1'b1);
        for (i = 0; i < QDEPTH; i++) begin
            seq = (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : 16'(i * 16'h1357) ^ 16'hA5A5;
            push_command(CMD_ENQUEUE, seq, i[0]);
        end
        // queue is full: this one must be dropped
        push_command(CMD_ENQUEUE, 16'h1234, 1'b1);
        // start, two resends, then give up and count an error
        repeat (4) push_command(CMD_TICK, 16'hFFFF, 1'b1);
        push_command(CMD_ACK, 16'h0000, 1'b0);
        push_command(CMD_TICK, 16'h0000, 1'b1);
        push_command(CMD_TICK, 16'h0000, 1'b1);
        push_command(CMD_ACK, 16'hFFFF, 1'b1);
        push_command(CMD_PORT_DOWN, 16'h0000, 1'b0);
        push_command(CMD_TICK, 16'h5A5A, 1'b1);
        push_command(CMD_TICK, 16'hFFFF, 1'b0);
    endtask

    task automatic push_random(input bit tick_only);
        int r;
        cmd_t c;
        logic tlv;
        c   = CMD_TICK;
        tlv = 1'b1;
        r   = $urandom_range(0, 99);
        if (tick_only) begin
            if (sb.fill == 0)
                c = CMD_ENQUEUE;
        end else if (burst_left > 0) begin
            c = CMD_ENQUEUE;
            burst_left--;
        end else if (r < 2) begin
            burst_left = $urandom_range(4, 20);
            c = CMD_ENQUEUE;
        end else if (r < 5) begin
            c = CMD_PORT_DOWN;
        end else if (r < 7) begin
            tlv = 1'b0;
        end else if (r < 22 || (sb.fill == 0 && r < 70)) begin
            c = CMD_ENQUEUE;
        end else if (r < 34) begin
            c = CMD_ACK;
        end
        if (c != CMD_TICK)
            tlv = 1'($urandom_range(0, 1));
        push_command(c, 16'($urandom_range(0, 65535)), tlv);
    endtask

    localparam int PH_RELOAD [NUM_PHASES] = '{30, 65535, 1, 65535, 1};
    localparam int PH_STEP   [NUM_PHASES] = '{10, 65535, 1, 1, 65535};
    localparam int PH_TRIES  [NUM_PHASES] = '{2, 255, 0, 1, 255};
    localparam int PH_SEND   [NUM_PHASES] = '{0, 80, 0, 32, 0};
    localparam int PH_STALL  [NUM_PHASES] = '{0, 0, 80, 32, 0};
    localparam int PH_ITEMS  [NUM_PHASES] = '{250, 200, 200, 200, 300};

    initial begin
        int p;
        int n;
        bit failed;
        sb = new();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        set_timing(16'd1, 16'hFFFF, 8'd3);
        run_directed();
        wait_results_drained();

        for (p = 0; p < NUM_PHASES; p++) begin
            send_idle_pct = PH_SEND[p];
            stall_pct     = PH_STALL[p];
            burst_left    = 0;
            set_timing(16'(PH_RELOAD[p]), 16'(PH_STEP[p]), 8'(PH_TRIES[p]));
            for (n = 0; n < PH_ITEMS[p]; n++) begin
                // last phase runs long tick streaks to exhaust the retry limit
                push_random(p == NUM_PHASES - 1);
                if (n == PH_ITEMS[p] / 2)
                    wait_results_drained();
            end
            wait_results_drained();
        end

        repeat (8) @(posedge aclk);
        failed = (sb.mismatches != 0) || (reg_errors != 0);
        if (sb.pending_results.size() != 0) begin
            $error("%0d expected results never arrived", sb.pending_results.size());
            failed = 1'b1;
        end
        if (!failed)
            $display("[ecp_transmit_retry_engine] OK");
        else
            $display("[ecp_transmit_retry_engine] ERROR");
        $finish;
    end

endmodule
